// File: design/assert_macros.svh
// Assertion helpers used by the design file bscff_ctrl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define BSC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BSC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bscff_pkg.sv
package bscff_pkg;

	localparam int WORD_BITS = 32;
	localparam int WB_LOG    = 5;
	localparam int SIZE_DEF  = 1024;
	localparam int BIU_W     = 11;
	localparam int IDX_W     = 10;
	localparam int KIND_W    = 3;
	// Widest word address over the whole SIZE range
	localparam int MADDR_W   = 11;

	localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

	localparam logic [KIND_W-1:0] KIND_TEST    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLR     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SET_ALL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLR_ALL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FFS     = 3'd5;
	localparam logic [KIND_W-1:0] KIND_FFC     = 3'd6;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  bit_index;
	} in_t;

	typedef struct packed {
		logic             bit_was_set;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic             out_of_range;
	} out_t;

	typedef struct packed {
		logic                 en;
		logic [MADDR_W-1:0]   addr;
		logic [WORD_BITS-1:0] data;
	} mem_wr_t;

endpackage

// File: design/bitmap_set_clear_find_first.sv
// Channel | Direction | Handshake          | Payload
// in      | in        | in_valid/in_stall  | in_item   (kind, bit_index)
// out     | out       | out_valid/out_stall| out_item  (bit_was_set, found, found_index,
//         |           |                    |            out_of_range)
// cfg     | in        | cfg_valid/cfg_ready| cfg_data  (bits_in_use)
//
// Test, set or clear steps through read, modify-write and result; out of range goes straight to result.
// Set all or clear all writes one memory word a cycle, then gives its result.
// A search reads one word a cycle through the single read port until a hit or the last live word.
// After reset the map is cleared by a fill pass over every word; in_stall stays high meanwhile.
// The output register lets a result wait under out_stall while the next item starts.
module bitmap_set_clear_find_first #(
	parameter int SIZE = bscff_pkg::SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bscff_pkg::in_t                in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bscff_pkg::out_t               out_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bscff_pkg::BIU_W-1:0]   cfg_data
);
	import bscff_pkg::*;

	localparam int DEPTH = (SIZE + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [BIU_W-1:0]     bits_in_use_q;
	mem_wr_t              mem_wr;
	logic [AW-1:0]        mem_rd_addr;
	logic [WORD_BITS-1:0] mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= BIU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bits_in_use_q <= cfg_data;
		end
	end

	bscff_ctrl #(
		.SIZE  (SIZE),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.bits_in_use (bits_in_use_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.mem_wr      (mem_wr),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	bscff_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr      (mem_wr),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

// File: design/bscff_mem.sv
module bscff_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                              clk,
	input  bscff_pkg::mem_wr_t                wr,
	input  logic [AW-1:0]                     rd_addr,
	output logic [bscff_pkg::WORD_BITS-1:0]   rd_data
);
	import bscff_pkg::*;

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: design/bscff_ctrl.sv
`include "assert_macros.svh"

module bscff_ctrl #(
	parameter int SIZE  = 1024,
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bscff_pkg::BIU_W-1:0]      bits_in_use,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  bscff_pkg::in_t                   in_item,
	output logic                             out_valid,
	input  logic                             out_stall,
	output bscff_pkg::out_t                  out_item,
	output bscff_pkg::mem_wr_t               mem_wr,
	output logic [AW-1:0]                    mem_rd_addr,
	input  logic [bscff_pkg::WORD_BITS-1:0]  mem_rd_data
);
	import bscff_pkg::*;

	localparam int CW = (AW + 6 > 12) ? AW + 6 : 12;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_RMW  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

	logic [2:0]        state_q;
	logic [AW-1:0]     ptr_q;
	logic [KIND_W-1:0] kind_q;
	logic [WB_LOG-1:0] bit_q;
	logic              fill_one_q;
	logic              respond_q;
	out_t              res_q;
	logic              out_valid_q;
	out_t              out_item_q;

	logic [CW-1:0]        n_w;
	logic [CW-1:0]        idx_ext;
	logic [CW-1:0]        widx;
	logic                 in_oor;
	logic                 accept;
	logic [CW-1:0]        base;
	logic [CW-1:0]        rem;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] low_one;
	logic                 hit;
	logic                 last;
	logic [WB_LOG-1:0]    hit_pos;
	logic [CW-1:0]        hit_index;
	logic                 out_load;

	// Bit position of a one-hot word
	function automatic logic [WB_LOG-1:0] onehot_pos(input logic [WORD_BITS-1:0] oh);
		logic [WB_LOG-1:0] pos;
		pos = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			pos = pos | (oh[i] ? WB_LOG'(i) : '0);
		end
		return pos;
	endfunction

	assign n_w     = (CW'(bits_in_use) > CW'(SIZE)) ? CW'(SIZE) : CW'(bits_in_use);
	assign idx_ext = CW'(in_item.bit_index);
	assign widx    = idx_ext >> WB_LOG;
	assign in_oor  = idx_ext >= n_w;
	assign in_stall = (state_q != ST_IDLE);
	assign accept  = in_valid && !in_stall;

	// Mask off bits at or above the valid count within the current word
	assign base    = CW'(ptr_q) << WB_LOG;
	assign rem     = n_w - base;
	assign mask    = (rem >= CW'(WORD_BITS)) ? '1 : ~({WORD_BITS{1'b1}} << rem[WB_LOG-1:0]);
	assign cand    = ((kind_q == KIND_FFS) ? mem_rd_data : ~mem_rd_data) & mask;
	assign low_one = cand & (~cand + WORD_BITS'(1));
	assign hit     = |cand;
	assign hit_pos = onehot_pos(low_one);
	assign hit_index = base + CW'(hit_pos);
	assign last    = (base + CW'(WORD_BITS)) >= n_w;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		mem_rd_addr = ptr_q;
		mem_wr      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_item.kind == KIND_FFS || in_item.kind == KIND_FFC || in_oor) begin
					mem_rd_addr = '0;
				end else begin
					mem_rd_addr = widx[AW-1:0];
				end
			end
			ST_FILL: begin
				mem_wr.en   = 1'b1;
				mem_wr.addr = MADDR_W'(ptr_q);
				mem_wr.data = {WORD_BITS{fill_one_q}};
			end
			ST_RMW: begin
				mem_wr.en   = (kind_q == KIND_SET) || (kind_q == KIND_CLR);
				mem_wr.addr = MADDR_W'(ptr_q);
				mem_wr.data = mem_rd_data;
				mem_wr.data[bit_q] = (kind_q == KIND_SET);
			end
			ST_SCAN: begin
				mem_rd_addr = (ptr_q == LAST_WORD) ? ptr_q : ptr_q + AW'(1);
			end
			default: begin
				mem_rd_addr = ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// Clear the whole map before taking any transaction
			state_q    <= ST_FILL;
			ptr_q      <= '0;
			kind_q     <= KIND_TEST;
			fill_one_q <= 1'b0;
			respond_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q <= in_item.kind;
						case (in_item.kind) inside
							KIND_TEST, KIND_SET, KIND_CLR: begin
								ptr_q   <= widx[AW-1:0];
								state_q <= in_oor ? ST_DONE : ST_RMW;
							end
							KIND_SET_ALL, KIND_CLR_ALL: begin
								fill_one_q <= (in_item.kind == KIND_SET_ALL);
								respond_q  <= 1'b1;
								ptr_q      <= '0;
								state_q    <= ST_FILL;
							end
							KIND_FFS, KIND_FFC: begin
								ptr_q   <= '0;
								state_q <= (n_w == '0) ? ST_DONE : ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_FILL: begin
					if (ptr_q == LAST_WORD) begin
						ptr_q   <= '0;
						state_q <= respond_q ? ST_DONE : ST_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_RMW: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (hit || last) begin
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload, built up while the transaction runs
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= {2'b00, {IDX_W{1'b0}}, in_oor && (in_item.kind == KIND_TEST ||
				in_item.kind == KIND_SET || in_item.kind == KIND_CLR)};
			bit_q <= in_item.bit_index[WB_LOG-1:0];
		end else if (state_q == ST_RMW) begin
			res_q.bit_was_set <= mem_rd_data[bit_q];
		end else if (state_q == ST_SCAN && hit) begin
			res_q.found       <= 1'b1;
			res_q.found_index <= hit_index[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_item_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`BSC_ASSERT_IMPL(a_wr_states, mem_wr.en, state_q == ST_FILL || state_q == ST_RMW, "bad write")
	`BSC_ASSERT_NEXT(a_out_from_done, out_load, out_valid, "result load did not raise valid")
	`BSC_ASSERT_IMPL(a_rmw_in_range, state_q == ST_RMW, !res_q.out_of_range && !res_q.found, "bad rmw")
	`BSC_ASSERT_IMPL(a_found_clean, out_item.found, !(out_item.out_of_range || out_item.bit_was_set), "mixed")

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import bscff_pkg::*;

	localparam int MAP_BITS = SIZE_DEF;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_t                in_item;
	logic               out_valid;
	logic               out_stall;
	out_t               out_item;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [BIU_W-1:0]   cfg_data;

	// Shadow of the map and of the bit count
	bit [MAP_BITS-1:0]  shadow_map;
	logic [BIU_W-1:0]   shadow_count;
	out_t               pending_results[$];
	int                 err_count = 0;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;

	bitmap_set_clear_find_first uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int live_bits();
		return (shadow_count > MAP_BITS) ? MAP_BITS : int'(shadow_count);
	endfunction

	// Apply one request to the shadow map and return the result it yields
	function automatic out_t apply_request(in_t req);
		out_t res;
		int   n;
		res = '0;
		n = live_bits();
		case (req.kind)
			KIND_TEST, KIND_SET, KIND_CLR: begin
				if (req.bit_index >= n) begin
					res.out_of_range = 1'b1;
				end else begin
					res.bit_was_set = shadow_map[req.bit_index];
					if (req.kind == KIND_SET)
						shadow_map[req.bit_index] = 1'b1;
					else if (req.kind == KIND_CLR)
						shadow_map[req.bit_index] = 1'b0;
				end
			end
			KIND_SET_ALL: shadow_map = '1;
			KIND_CLR_ALL: shadow_map = '0;
			KIND_FFS, KIND_FFC: begin
				for (int i = 0; i < n; i++) begin
					if (!res.found && shadow_map[i] == (req.kind == KIND_FFS)) begin
						res.found = 1'b1;
						res.found_index = i[IDX_W-1:0];
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
		in_t req;
		req.kind = kind;
		req.bit_index = idx;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_request(req));
	endtask

	// Drop valid, then wait for every outstanding transaction to come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (MAP_BITS / WORD_BITS + 4) @(posedge clk);
	endtask

	task automatic write_bits_in_use(input logic [BIU_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		shadow_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	task automatic check_field(input string label, input logic [IDX_W-1:0] expd,
			input logic [IDX_W-1:0] got);
		if (got !== expd) begin
			$display("%0t: %s mismatch: expected %0d actual %0d", $time, label, expd, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		out_t expd;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none actual %h", $time, out_item);
				err_count++;
			end else begin
				expd = pending_results.pop_front();
				check_field("bit_was_set", expd.bit_was_set, out_item.bit_was_set);
				check_field("found", expd.found, out_item.found);
				check_field("found_index", expd.found_index, out_item.found_index);
				check_field("out_of_range", expd.out_of_range, out_item.out_of_range);
			end
		end
	end

	task automatic test_single_bits();
		send_request(KIND_TEST, 10'd0);
		send_request(KIND_SET, 10'd0);
		send_request(KIND_SET, 10'd0);
		send_request(KIND_SET, 10'd1023);
		send_request(KIND_TEST, 10'd1023);
		send_request(KIND_CLR, 10'd1023);
		send_request(KIND_CLR, 10'd1023);
	endtask

	task automatic test_searches();
		send_request(KIND_CLR_ALL, 10'h3ff);
		send_request(KIND_FFS, 10'd0);
		send_request(KIND_FFC, 10'h155);
		send_request(KIND_SET, 10'd700);
		send_request(KIND_FFS, 10'h2aa);
		send_request(KIND_SET_ALL, 10'd0);
		send_request(KIND_FFC, 10'd0);
		send_request(KIND_CLR, 10'd3);
		send_request(KIND_FFC, 10'd0);
		send_request(KIND_UNUSED, 10'h3ff);
	endtask

	task automatic test_count_limits();
		wait_idle();
		write_bits_in_use(11'd10);
		send_request(KIND_TEST, 10'd10);
		send_request(KIND_CLR, 10'd9);
		send_request(KIND_FFC, 10'd0);
		wait_idle();
		write_bits_in_use(11'd0);
		send_request(KIND_SET, 10'd0);
		send_request(KIND_FFS, 10'd0);
		wait_idle();
		write_bits_in_use(11'h7ff);
		send_request(KIND_TEST, 10'd1023);
		send_request(KIND_FFC, 10'd0);
		wait_idle();
		write_bits_in_use(11'd1);
		send_request(KIND_CLR, 10'd1);
		send_request(KIND_FFC, 10'd0);
		wait_idle();
		write_bits_in_use(BIU_RESET);
	endtask

	function automatic logic [BIU_W-1:0] pick_count();
		case ($urandom_range(9))
			0: return BIU_RESET;
			1: return '0;
			2: return BIU_W'($urandom_range(2047, MAP_BITS + 1));
			3: return 11'd1;
			4: return BIU_W'($urandom_range(40, 1));
			default: return BIU_W'($urandom_range(MAP_BITS, 1));
		endcase
	endfunction

	task automatic test_random(input int total);
		int                sent;
		int                chunk;
		int                n;
		int                sel;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		sent = 0;
		while (sent < total) begin
			wait_idle();
			write_bits_in_use(pick_count());
			n = live_bits();
			chunk = $urandom_range(80, 40);
			repeat (chunk) begin
				sel = $urandom_range(99);
				if (sel < 2)       kind = KIND_UNUSED;
				else if (sel < 6)  kind = KIND_SET_ALL;
				else if (sel < 10) kind = KIND_CLR_ALL;
				else if (sel < 24) kind = KIND_FFS;
				else if (sel < 38) kind = KIND_FFC;
				else if (sel < 55) kind = KIND_TEST;
				else if (sel < 80) kind = KIND_SET;
				else               kind = KIND_CLR;
				sel = $urandom_range(99);
				// keep most indices inside the live bits, some crowded at the bottom
				if (sel < 20 || n == 0)
					idx = IDX_W'($urandom_range(1023));
				else if (sel < 35)
					idx = IDX_W'($urandom_range((n < 64) ? n - 1 : 63));
				else
					idx = IDX_W'($urandom_range(n - 1));
				send_request(kind, idx);
			end
			sent += chunk;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		shadow_map = '0;
		shadow_count = BIU_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 37;
		recv_stall_pct = 47;
		test_single_bits();
		test_searches();
		test_count_limits();
		test_random(330);

		send_idle_pct = 47;
		recv_stall_pct = 37;
		test_random(330);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(330);

		wait_idle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/bscff_pkg.sv
design/bscff_mem.sv
design/bscff_ctrl.sv
design/bitmap_set_clear_find_first.sv
bench/testbench.sv
